@@ hw/rtl/ast_pkg.sv @@
// shared types and constants for the announcement switch tracker
// no dependencies; imported by the entry update logic and the top level
package ast_pkg;

  // per-cluster status codes
  typedef enum logic [1:0] {
    StIdle     = 2'd0,
    StNew      = 2'd1,
    StRepeated = 2'd2,
    StDisabled = 2'd3
  } status_e;

  localparam int unsigned DefaultClusters = 32;
  localparam int unsigned IndexWidth      = 5;
  localparam int unsigned CountWidth      = 8;
  localparam int unsigned DataWidth       = 32;
  localparam int unsigned AddrWidth       = 3;

  // timeout register reset: 2000 ms / 24 ms frames
  localparam logic [CountWidth-1:0] TimeoutReset = CountWidth'(2000 / 24);

  // register index, taken from paddr[2]
  localparam logic RegTimeout = 1'b0;

  // result of one entry update
  typedef struct packed {
    status_e               status;
    logic [CountWidth-1:0] count;
    logic                  enter_fast;
    logic                  leave_fast;
  } entry_upd_t;

  // new and disabled clusters are sent at the fast rate
  function automatic logic is_fast(status_e st);
    return (st == StNew) || (st == StDisabled);
  endfunction

endpackage

@@ hw/rtl/announcement_switch_tracker_unit.sv @@
// top level of the announcement switch tracker: tables, counters, handshakes
// depends on ast_pkg and ast_entry_update
//
// Each accepted transaction is one observation of one cluster. It is taken
// into an input register; when the result register can advance, the cluster's
// status and countdown are read from flip-flop tables, updated, written back
// and placed in the result register. A new observation is accepted every
// cycle while results are taken.
// Observations of a cluster index of CLUSTERS or more change nothing and
// return status idle and countdown zero. fast_rate is high while any cluster
// is new or disabled. The timeout register (byte address 0) is loaded into
// the countdown on entry to new or disabled; write it only while idle.
module announcement_switch_tracker_unit
  import ast_pkg::*;
#(
  parameter int unsigned CLUSTERS = DefaultClusters
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrWidth-1:0]  paddr,
  input  logic [DataWidth-1:0]  pwdata,
  output logic [DataWidth-1:0]  prdata,
  output logic                  pready,
  // observation channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [IndexWidth-1:0] cluster_index_i,
  input  logic                  cluster_active_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            cluster_status_o,
  output logic [CountWidth-1:0] countdown_left_o,
  output logic                  fast_rate_o
);

  // only indexes below 2**IndexWidth are reachable
  localparam int unsigned MaxIndexed = 2 ** IndexWidth;
  localparam int unsigned Depth      = (CLUSTERS < MaxIndexed) ? CLUSTERS : MaxIndexed;
  localparam int unsigned TabIdxW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FastCntW   = $clog2(Depth + 1);

  logic [CountWidth-1:0] timeout_q;

  logic                  s1_valid_q;
  logic [IndexWidth-1:0] s1_index_q;
  logic                  s1_active_q;

  status_e               status_tab_q [Depth];
  logic [CountWidth-1:0] count_tab_q  [Depth];
  logic [FastCntW-1:0]   fast_cnt_q;
  logic [FastCntW-1:0]   fast_cnt_d;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [CountWidth-1:0] out_count_q;
  logic                  out_fast_q;

  logic                  advance;
  logic                  in_range;
  logic [TabIdxW-1:0]    tab_idx;
  status_e               old_status;
  logic [CountWidth-1:0] old_count;
  entry_upd_t            upd;
  status_e               res_status;
  logic [CountWidth-1:0] res_count;
  logic                  cfg_write;

  // configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_write && (paddr[2] == RegTimeout)) begin
      timeout_q <= pwdata[CountWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegTimeout) begin
      prdata = DataWidth'(timeout_q);
    end
  end

  // handshakes
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_index_q  <= cluster_index_i;
      s1_active_q <= cluster_active_i;
    end
  end

  // table read
  assign in_range = (int'(s1_index_q) < int'(CLUSTERS));
  assign tab_idx  = TabIdxW'(s1_index_q);

  always_comb begin
    old_status = StIdle;
    old_count  = '0;
    if (in_range) begin
      old_status = status_tab_q[tab_idx];
      old_count  = count_tab_q[tab_idx];
    end
  end

  ast_entry_update u_entry_update (
    .old_status_i (old_status),
    .old_count_i  (old_count),
    .active_i     (s1_active_q),
    .timeout_i    (timeout_q),
    .upd_o        (upd)
  );

  // result values and fast entry count
  always_comb begin
    res_status = StIdle;
    res_count  = '0;
    fast_cnt_d = fast_cnt_q;
    if (in_range) begin
      res_status = upd.status;
      res_count  = upd.count;
      if (upd.leave_fast && (fast_cnt_q != '0)) begin
        fast_cnt_d = fast_cnt_q - FastCntW'(1);
      end else if (upd.enter_fast) begin
        fast_cnt_d = fast_cnt_q + FastCntW'(1);
      end
    end
  end

  // table write-back and fast count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(Depth); i++) begin
        status_tab_q[i] <= StIdle;
        count_tab_q[i]  <= '0;
      end
      fast_cnt_q <= '0;
    end else if (s1_valid_q && advance) begin
      if (in_range) begin
        status_tab_q[tab_idx] <= upd.status;
        count_tab_q[tab_idx]  <= upd.count;
      end
      fast_cnt_q <= fast_cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      out_status_q <= res_status;
      out_count_q  <= res_count;
      out_fast_q   <= (fast_cnt_d != '0);
    end
  end

  assign cluster_status_o = out_status_q;
  assign countdown_left_o = out_count_q;
  assign fast_rate_o      = out_fast_q;

endmodule

@@ hw/rtl/ast_entry_update.sv @@
// next status and countdown of one cluster entry
// depends on ast_pkg
module ast_entry_update
  import ast_pkg::*;
(
  input  status_e               old_status_i,
  input  logic [CountWidth-1:0] old_count_i,
  input  logic                  active_i,
  input  logic [CountWidth-1:0] timeout_i,
  output entry_upd_t            upd_o
);

  status_e               status;
  logic [CountWidth-1:0] count;
  logic                  count_expired;

  assign count_expired = (old_count_i <= CountWidth'(1));

  // status transition
  always_comb begin
    status = old_status_i;
    count  = old_count_i;
    if (active_i) begin
      unique case (old_status_i)
        StNew: begin
          if (count_expired) begin
            status = StRepeated;
            count  = '0;
          end else begin
            count = old_count_i - CountWidth'(1);
          end
        end
        StIdle, StDisabled: begin
          status = StNew;
          count  = timeout_i;
        end
        default: begin
          status = old_status_i;
          count  = old_count_i;
        end
      endcase
    end else begin
      unique case (old_status_i)
        StDisabled: begin
          if (count_expired) begin
            status = StIdle;
            count  = '0;
          end else begin
            count = old_count_i - CountWidth'(1);
          end
        end
        StNew, StRepeated: begin
          status = StDisabled;
          count  = timeout_i;
        end
        default: begin
          status = old_status_i;
          count  = old_count_i;
        end
      endcase
    end
  end

  // fast-rate membership change
  assign upd_o.status     = status;
  assign upd_o.count      = count;
  assign upd_o.enter_fast = !is_fast(old_status_i) && is_fast(status);
  assign upd_o.leave_fast = is_fast(old_status_i) && !is_fast(status);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// testbench for the announcement switch tracker: directed table, then random phases
// depends on ast_pkg and announcement_switch_tracker_unit
module tb;
  import ast_pkg::*;

  localparam int unsigned NumClusters   = DefaultClusters;
  localparam int unsigned RandomItems   = 1100;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;

  typedef enum logic {
    RowObs,
    RowCfg
  } row_kind_e;

  // one predicted cluster update, in acceptance order
  typedef struct {
    logic [IndexWidth-1:0] idx;
    status_e               status;
    logic [CountWidth-1:0] count;
    logic                  fast;
  } cluster_update_t;

  // one row of the directed table
  typedef struct {
    row_kind_e             kind;
    logic [CountWidth-1:0] cfg;
    logic [IndexWidth-1:0] idx;
    logic                  act;
    bit                    lit;
    status_e               status;
    logic [CountWidth-1:0] count;
    logic                  fast;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [AddrWidth-1:0]  paddr;
  logic [DataWidth-1:0]  pwdata;
  logic [DataWidth-1:0]  prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [IndexWidth-1:0] cluster_index_i;
  logic                  cluster_active_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            cluster_status_o;
  logic [CountWidth-1:0] countdown_left_o;
  logic                  fast_rate_o;

  // predictor state
  status_e               status_mem [NumClusters];
  logic [CountWidth-1:0] count_mem  [NumClusters];
  int                    fast_cnt;
  logic [CountWidth-1:0] timeout_q;

  cluster_update_t cluster_updates_q [$];
  int              err_count;
  bit              calm;

  announcement_switch_tracker_unit #(
    .CLUSTERS(NumClusters)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cluster_index_i (cluster_index_i),
    .cluster_active_i(cluster_active_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cluster_status_o(cluster_status_o),
    .countdown_left_o(countdown_left_o),
    .fast_rate_o     (fast_rate_o)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // status and countdown update of one observed cluster
  function automatic cluster_update_t track_observation(input logic [IndexWidth-1:0] idx,
                                                        input logic act);
    cluster_update_t       r;
    status_e               st;
    logic [CountWidth-1:0] cnt;
    logic                  was_fast;
    logic                  now_fast;
    r.idx    = idx;
    r.status = StIdle;
    r.count  = '0;
    if (int'(idx) < int'(NumClusters)) begin
      st       = status_mem[idx];
      cnt      = count_mem[idx];
      was_fast = (st == StNew) || (st == StDisabled);
      if (act) begin
        if (st == StNew) begin
          if (cnt <= 1) begin
            st  = StRepeated;
            cnt = '0;
          end else begin
            cnt = cnt - 1'b1;
          end
        end else if (st == StIdle || st == StDisabled) begin
          st  = StNew;
          cnt = timeout_q;
        end
      end else begin
        if (st == StDisabled) begin
          if (cnt <= 1) begin
            st  = StIdle;
            cnt = '0;
          end else begin
            cnt = cnt - 1'b1;
          end
        end else if (st == StNew || st == StRepeated) begin
          st  = StDisabled;
          cnt = timeout_q;
        end
      end
      now_fast = (st == StNew) || (st == StDisabled);
      if (was_fast && !now_fast && fast_cnt > 0) fast_cnt--;
      else if (!was_fast && now_fast) fast_cnt++;
      status_mem[idx] = st;
      count_mem[idx]  = cnt;
      r.status        = st;
      r.count         = cnt;
    end
    r.fast = (fast_cnt > 0);
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_pause(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic dir_row_t obs_row(input logic [IndexWidth-1:0] idx, input logic act);
    dir_row_t r;
    r.kind   = RowObs;
    r.cfg    = '0;
    r.idx    = idx;
    r.act    = act;
    r.lit    = 1'b0;
    r.status = StIdle;
    r.count  = '0;
    r.fast   = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t lit_row(input logic [IndexWidth-1:0] idx, input logic act,
                                       input status_e st, input logic [CountWidth-1:0] cnt,
                                       input logic fast);
    dir_row_t r;
    r        = obs_row(idx, act);
    r.lit    = 1'b1;
    r.status = st;
    r.count  = cnt;
    r.fast   = fast;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CountWidth-1:0] v);
    dir_row_t r;
    r.kind   = RowCfg;
    r.cfg    = v;
    r.idx    = '0;
    r.act    = 1'b0;
    r.lit    = 1'b0;
    r.status = StIdle;
    r.count  = '0;
    r.fast   = 1'b0;
    return r;
  endfunction

  // one mismatch line
  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    $display("%0t ns: %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    err_count++;
  endtask

  // one observation transaction; predicts its update on acceptance
  task automatic send_obs(input logic [IndexWidth-1:0] idx, input logic act, input bit lit,
                          input status_e st, input logic [CountWidth-1:0] cnt,
                          input logic fast);
    int              pause;
    cluster_update_t upd;
    pause = pick_pause(calm);
    if (pause > 0) begin
      in_valid_i = 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    cluster_index_i  = idx;
    cluster_active_i = act;
    in_valid_i       = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    upd = track_observation(idx, act);
    if (lit) begin
      upd.status = st;
      upd.count  = cnt;
      upd.fast   = fast;
    end
    cluster_updates_q.push_back(upd);
    @(negedge clk_i);
  endtask

  // stop sending and wait for every pending update
  task automatic drain_updates();
    in_valid_i = 1'b0;
    while (cluster_updates_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // register access: setup cycle, then access cycle
  task automatic apb_access(input logic wr, input logic [DataWidth-1:0] wdata,
                            output logic [DataWidth-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {RegTimeout, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_timeout_reg();
    logic [DataWidth-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[CountWidth-1:0] !== timeout_q)
      report("timeout register read", 32'(timeout_q), rd);
  endtask

  task automatic write_timeout(input logic [CountWidth-1:0] v);
    logic [DataWidth-1:0] rd;
    drain_updates();
    apb_access(1'b1, DataWidth'(v), rd);
    timeout_q = v;
    check_timeout_reg();
  endtask

  // result side: random stalls
  initial begin : result_sink
    int hold_left;
    out_ready_i = 1'b0;
    hold_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) hold_left = pick_pause(1'b0);
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    cluster_update_t upd;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cluster_updates_q.size() == 0) begin
        report("result with no pending observation", 0, 32'(cluster_status_o));
      end else begin
        upd = cluster_updates_q.pop_front();
        if (cluster_status_o !== upd.status)
          report($sformatf("cluster %0d status", upd.idx), 32'(upd.status),
                 32'(cluster_status_o));
        if (countdown_left_o !== upd.count)
          report($sformatf("cluster %0d countdown", upd.idx), 32'(upd.count),
                 32'(countdown_left_o));
        if (fast_rate_o !== upd.fast)
          report($sformatf("cluster %0d fast_rate", upd.idx), 32'(upd.fast),
                 32'(fast_rate_o));
      end
    end
  end

  // watchdog: cycles with no transaction on any port
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb NOT OK");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    dir_row_t              dir_rows [$];
    dir_row_t              row;
    int                    sent;
    int                    plen;
    int                    n;
    int                    mode;
    int                    pick;
    int                    pool_size;
    int                    run_len;
    int                    t_cap;
    logic [IndexWidth-1:0] pool_base;
    logic [IndexWidth-1:0] cl;
    logic [CountWidth-1:0] tmo;

    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid_i       = 1'b0;
    cluster_index_i  = '0;
    cluster_active_i = 1'b0;
    calm             = 1'b0;
    err_count        = 0;
    fast_cnt         = 0;
    timeout_q        = TimeoutReset;
    for (int i = 0; i < int'(NumClusters); i++) begin
      status_mem[i] = StIdle;
      count_mem[i]  = '0;
    end

    // reset
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    check_timeout_reg();

    // directed table: reset timeout first
    dir_rows.push_back(lit_row(5'd0, 1'b0, StIdle, 8'd0, 1'b0));
    dir_rows.push_back(lit_row(5'd31, 1'b1, StNew, 8'd83, 1'b1));
    dir_rows.push_back(obs_row(5'd31, 1'b1));
    dir_rows.push_back(lit_row(5'd31, 1'b0, StDisabled, 8'd83, 1'b1));
    dir_rows.push_back(obs_row(5'd31, 1'b0));
    dir_rows.push_back(obs_row(5'd31, 1'b1));
    dir_rows.push_back(obs_row(5'd0, 1'b1));
    // shortest timeout: new and disabled last one frame
    dir_rows.push_back(cfg_row(8'd1));
    dir_rows.push_back(lit_row(5'd5, 1'b1, StNew, 8'd1, 1'b1));
    dir_rows.push_back(lit_row(5'd5, 1'b1, StRepeated, 8'd0, 1'b1));
    dir_rows.push_back(obs_row(5'd5, 1'b1));
    dir_rows.push_back(obs_row(5'd5, 1'b0));
    dir_rows.push_back(obs_row(5'd5, 1'b0));
    dir_rows.push_back(obs_row(5'd5, 1'b0));
    // zero timeout: loaded as zero, left at the next observation
    dir_rows.push_back(cfg_row(8'd0));
    dir_rows.push_back(lit_row(5'd10, 1'b1, StNew, 8'd0, 1'b1));
    dir_rows.push_back(lit_row(5'd10, 1'b1, StRepeated, 8'd0, 1'b1));
    dir_rows.push_back(lit_row(5'd10, 1'b0, StDisabled, 8'd0, 1'b1));
    dir_rows.push_back(obs_row(5'd10, 1'b0));
    // largest timeout
    dir_rows.push_back(cfg_row(8'd255));
    dir_rows.push_back(obs_row(5'd31, 1'b1));
    dir_rows.push_back(lit_row(5'd31, 1'b0, StDisabled, 8'd255, 1'b1));
    dir_rows.push_back(obs_row(5'd0, 1'b0));
    dir_rows.push_back(obs_row(5'd31, 1'b1));
    dir_rows.push_back(obs_row(5'd21, 1'b1));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == RowCfg) write_timeout(row.cfg);
      else send_obs(row.idx, row.act, row.lit, row.status, row.count, row.fast);
    end

    // random phases, each with its own timeout and cluster pool
    sent = 0;
    while (sent < int'(RandomItems)) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) tmo = 8'd0;
      else if (pick == 1) tmo = 8'd255;
      else if (pick == 2) tmo = 8'd1;
      else if (pick < 12) tmo = CountWidth'($urandom_range(2, 6));
      else tmo = CountWidth'($urandom_range(7, 40));
      write_timeout(tmo);
      calm      = ($urandom_range(0, 3) == 0);
      plen      = $urandom_range(40, 120);
      mode      = $urandom_range(0, 4);
      pool_base = IndexWidth'($urandom_range(0, 31));
      pool_size = $urandom_range(1, 4);
      t_cap     = (int'(tmo) > 40) ? 40 : int'(tmo);
      n         = 0;
      while (n < plen) begin
        if (mode == 0 || $urandom_range(0, 9) == 0) begin
          // noise or a broken sequence
          send_obs(IndexWidth'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 1'b0,
                   StIdle, '0, 1'b0);
          n++;
        end else begin
          // active run, then inactive run, on one pool cluster
          cl      = pool_base + IndexWidth'($urandom_range(0, pool_size - 1));
          run_len = $urandom_range(0, t_cap + 2);
          for (int k = 0; k < run_len && n < plen; k++) begin
            send_obs(cl, 1'b1, 1'b0, StIdle, '0, 1'b0);
            n++;
          end
          run_len = $urandom_range(0, t_cap + 2);
          for (int k = 0; k < run_len && n < plen; k++) begin
            send_obs(cl, 1'b0, 1'b0, StIdle, '0, 1'b0);
            n++;
          end
        end
        // sender holds off until every update has come back
        if ($urandom_range(0, 149) == 0) drain_updates();
      end
      sent += n;
    end

    // wind down
    calm = 1'b0;
    drain_updates();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
